// ----- hdl/apt_pkg.sv -----
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types and constants for the affine point transform unit: element
// format, matrix geometry, request kinds and the matrix write bundle.
// ----------------------------------------------------------------------------
package apt_pkg;

   localparam int ELEM_W         = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int MAT_DIM        = 4;
   localparam int MAT_DEPTH      = MAT_DIM * MAT_DIM;
   localparam int DIM_IDX_W      = $clog2(MAT_DIM);
   localparam int MAT_IDX_W      = $clog2(MAT_DEPTH);
   localparam int COORD_CNT      = 3;
   localparam int PROD_W         = 2 * ELEM_W;

   typedef logic signed [ELEM_W-1:0] elem_type;

   typedef enum logic [1:0] {
      REQ_WRITE  = 2'd0,
      REQ_READ   = 2'd1,
      REQ_POINT  = 2'd2,
      REQ_VECTOR = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic                 en;
      logic [MAT_IDX_W-1:0] idx;
      elem_type             data;
   } mat_wr_type;

endpackage

// ----- hdl/apt_matrix.sv -----
// ----------------------------------------------------------------------------
// apt_matrix
// 4x4 row-major matrix of fixed-point elements in flops. Reset loads the
// identity. One element write and one element read port; every element is
// also presented for the transform datapath.
// ----------------------------------------------------------------------------
module apt_matrix
   import apt_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mat_wr_type           wr,
   input  logic [MAT_IDX_W-1:0] rd_idx,
   output elem_type             rd_data,
   output elem_type             mat [MAT_DEPTH]
);

   localparam elem_type ONE = elem_type'(ELEM_W'(1) << FRAC_BITS);

   elem_type mat_ff [MAT_DEPTH];
   elem_type mat_in [MAT_DEPTH];

   always_comb begin
      mat_in = mat_ff;
      if (wr.en) begin
         mat_in[wr.idx] = wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAT_DEPTH; i++) begin
            mat_ff[i] <= ((i / MAT_DIM) == (i % MAT_DIM)) ? ONE : '0;
         end
      end else begin
         mat_ff <= mat_in;
      end
   end

   assign rd_data = mat_ff[rd_idx];
   assign mat     = mat_ff;

endmodule

// ----- hdl/apt_row_dot.sv -----
// ----------------------------------------------------------------------------
// apt_row_dot
// One output component: three signed products floored to the fixed-point
// grid, optional translation term, exact sum and clamp to 32 bits.
// ----------------------------------------------------------------------------
module apt_row_dot
   import apt_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  elem_type row_elem [MAT_DIM],
   input  elem_type coord    [COORD_CNT],
   input  logic     add_offset,
   output elem_type dot,
   output logic     sat
);

   localparam int SHF_W = PROD_W - FRAC_BITS;
   localparam int SUM_W = SHF_W + 2;

   logic signed [PROD_W-1:0] prod [COORD_CNT];
   logic signed [SHF_W-1:0]  shf  [COORD_CNT];
   logic signed [SUM_W-1:0]  offset;
   logic signed [SUM_W-1:0]  sum;
   logic                     fits;

   always_comb begin
      for (int i = 0; i < COORD_CNT; i++) begin
         prod[i] = PROD_W'(row_elem[i]) * PROD_W'(coord[i]);
         shf[i]  = $signed(prod[i][PROD_W-1:FRAC_BITS]);
      end
      offset = add_offset ? SUM_W'(row_elem[MAT_DIM-1]) : '0;
      sum    = SUM_W'(shf[0]) + SUM_W'(shf[1]) + SUM_W'(shf[2]) + offset;
      fits   = (&sum[SUM_W-1:ELEM_W-1]) || !(|sum[SUM_W-1:ELEM_W-1]);
      sat    = !fits;
      if (fits) begin
         dot = sum[ELEM_W-1:0];
      end else if (sum[SUM_W-1]) begin
         dot = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         dot = {1'b0, {(ELEM_W-1){1'b1}}};
      end
   end

endmodule

// ----- hdl/affine_point_transform_unit.sv -----
// ----------------------------------------------------------------------------
// affine_point_transform_unit
// Takes one request per cycle and returns one response per request, in order.
// A request is registered, executed in a single pass through nine parallel
// 32x32 multipliers with their adders and clamps, and its response registered:
// the request stage register feeds the response register, and throughput is one
// request per cycle, limited only by response back-pressure. The matrix
// resets to the identity; an element write takes effect for the very next
// request. Write responses are all zero, read responses carry the element in
// res_x, and transform responses flag any clamped component in saturated.
// ----------------------------------------------------------------------------
module affine_point_transform_unit
   import apt_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   input  logic [DIM_IDX_W-1:0] req_row_index,
   input  logic [DIM_IDX_W-1:0] req_col_index,
   input  elem_type             req_element_value,
   input  elem_type             req_coord_x,
   input  elem_type             req_coord_y,
   input  elem_type             req_coord_z,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output elem_type             rsp_res_x,
   output elem_type             rsp_res_y,
   output elem_type             rsp_res_z,
   output logic                 rsp_saturated
);

   logic                 stg_valid_ff;
   req_kind_type         kind_ff;
   logic [MAT_IDX_W-1:0] idx_ff;
   elem_type             value_ff;
   elem_type             coord_ff [COORD_CNT];

   logic                 rsp_valid_ff;
   elem_type             res_ff   [COORD_CNT];
   logic                 sat_ff;

   elem_type             res_in   [COORD_CNT];
   logic                 sat_in;

   logic                 out_free;
   logic                 advance;
   logic                 req_fire;

   mat_wr_type           wr;
   elem_type             rd_data;
   elem_type             mat      [MAT_DEPTH];
   elem_type             row_elem [COORD_CNT][MAT_DIM];
   elem_type             dot      [COORD_CNT];
   logic [COORD_CNT-1:0] dot_sat;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = stg_valid_ff && out_free;
   assign req_ready = !stg_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stg_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff     <= req_kind_type'(req_type);
         idx_ff      <= {req_row_index, req_col_index};
         value_ff    <= req_element_value;
         coord_ff[0] <= req_coord_x;
         coord_ff[1] <= req_coord_y;
         coord_ff[2] <= req_coord_z;
      end
   end

   assign wr.en   = advance && (kind_ff == REQ_WRITE);
   assign wr.idx  = idx_ff;
   assign wr.data = value_ff;

   apt_matrix #(
      .FRAC_BITS (FRAC_BITS)
   ) u_matrix (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_idx  (idx_ff),
      .rd_data (rd_data),
      .mat     (mat)
   );

   always_comb begin
      for (int r = 0; r < COORD_CNT; r++) begin
         for (int c = 0; c < MAT_DIM; c++) begin
            row_elem[r][c] = mat[r * MAT_DIM + c];
         end
      end
   end

   for (genvar r = 0; r < COORD_CNT; r++) begin : g_row
      apt_row_dot #(
         .FRAC_BITS (FRAC_BITS)
      ) u_row_dot (
         .row_elem   (row_elem[r]),
         .coord      (coord_ff),
         .add_offset (kind_ff == REQ_POINT),
         .dot        (dot[r]),
         .sat        (dot_sat[r])
      );
   end

   always_comb begin
      for (int r = 0; r < COORD_CNT; r++) begin
         res_in[r] = '0;
      end
      sat_in = 1'b0;
      unique case (kind_ff)
         REQ_WRITE: begin
         end
         REQ_READ: begin
            res_in[0] = rd_data;
         end
         REQ_POINT, REQ_VECTOR: begin
            res_in = dot;
            sat_in = |dot_sat;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= stg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_res_x     = res_ff[0];
   assign rsp_res_y     = res_ff[1];
   assign rsp_res_z     = res_ff[2];
   assign rsp_saturated = sat_ff;

endmodule

// ----- hdl/apt_checker.sv -----
// ----------------------------------------------------------------------------
// apt_checker
// Port-level checks for the affine point transform unit, bound to the top.
// ----------------------------------------------------------------------------
module apt_checker
   import apt_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input elem_type             rsp_res_x,
   input elem_type             rsp_res_y,
   input elem_type             rsp_res_z,
   input logic                 rsp_saturated
);

   localparam elem_type EMAX = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam elem_type EMIN = {1'b1, {(ELEM_W-1){1'b0}}};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_res_x)
         && $stable(rsp_res_y) && $stable(rsp_res_z) && $stable(rsp_saturated))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without response back-pressure");

   a_sat_at_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_res_x == EMAX || rsp_res_x == EMIN ||
         rsp_res_y == EMAX || rsp_res_y == EMIN ||
         rsp_res_z == EMAX || rsp_res_z == EMIN)
      else $error("saturated flag without a clamped component");

endmodule

bind affine_point_transform_unit apt_checker u_apt_checker (.*);
